@@ hdl/nsva_pkg.sv @@
// nsva_pkg: shared types and constants for the note stack voice allocator
// used by nsva_front, nsva_back and the top level; no dependencies
package nsva_pkg;

   localparam logic ACTION_ON  = 1'b0;
   localparam logic ACTION_OFF = 1'b1;

   localparam logic KIND_VOICE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] CSR_POLYPHONY   = 2'd0;
   localparam logic [1:0] CSR_LOWEST_NOTE = 2'd1;
   localparam logic [1:0] CSR_NOTE_SPAN   = 2'd2;

   localparam logic [3:0] POLYPHONY_RESET   = 4'd1;
   localparam logic [6:0] LOWEST_NOTE_RESET = 7'd48;
   localparam logic [6:0] NOTE_SPAN_RESET   = 7'd53;

   // classified note event passed from front to back
   typedef struct packed {
      logic       action;
      logic [6:0] pitch;
      logic       ignored;
   } event_type;

endpackage

@@ hdl/nsva_front.sv @@
// nsva_front: accepts note events, checks the pitch window, two-entry queue
// depends on nsva_pkg
module nsva_front
   import nsva_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic      req_action,
   input  logic [6:0] req_pitch,
   input  logic [6:0] lowest_note,
   input  logic [6:0] note_span,
   output logic      ev_valid,
   input  logic      ev_ready,
   output event_type ev
);

   event_type  q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   logic [7:0] hi_bound;
   logic       in_window;
   event_type  cls;

   assign hi_bound  = {1'b0, lowest_note} + {1'b0, note_span};
   assign in_window = (req_pitch >= lowest_note) && ({1'b0, req_pitch} < hi_bound);

   always_comb begin
      cls.action  = req_action;
      cls.pitch   = req_pitch;
      cls.ignored = !in_window;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign ev_valid  = (cnt_ff != 2'd0);
   assign ev        = q_ff[rd_ff];
   assign push      = req_valid && req_ready;
   assign pop       = ev_valid && ev_ready;

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule

@@ hdl/nsva_back.sv @@
// nsva_back: held-note stack, voice free and assign passes, result register
// depends on nsva_pkg
module nsva_back
   import nsva_pkg::*;
#(
   parameter int STACK_DEPTH = 10,
   parameter int VOICES      = 8
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic [3:0] polyphony,
   input  logic       ev_valid,
   output logic       ev_ready,
   input  event_type  ev,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [2:0] rsp_voice,
   output logic [6:0] rsp_voice_pitch,
   output logic       rsp_retrigger,
   output logic [3:0] rsp_held_count,
   output logic       rsp_gate,
   output logic       rsp_ignored,
   output logic       rsp_last
);

   localparam int SW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FREE   = 2'd1;
   localparam logic [1:0] ST_ASSIGN = 2'd2;
   localparam logic [1:0] ST_STATUS = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [6:0]    held_ff [STACK_DEPTH];
   logic [6:0]    held_in [STACK_DEPTH];
   logic [CW-1:0] total_ff, total_in;
   logic [6:0]    voice_ff [VOICES];
   logic [6:0]    voice_in [VOICES];
   logic          gate_ff, gate_in;
   logic [VW-1:0] vidx_ff, vidx_in;
   logic [CW-1:0] sidx_ff, sidx_in;
   logic          ign_ff, ign_in;

   logic          rsp_valid_ff;
   logic          rsp_kind_ff, rsp_retrigger_ff, rsp_gate_ff, rsp_ignored_ff, rsp_last_ff;
   logic [2:0]    rsp_voice_ff;
   logic [6:0]    rsp_voice_pitch_ff;
   logic [3:0]    rsp_held_count_ff;

   logic          emit, e_kind, e_retrig, e_gate, e_ign, e_last;
   logic [2:0]    e_voice;
   logic [6:0]    e_pitch;

   logic [7:0]    poly8, tot8, first8;
   logic [CW-1:0] first;
   logic [STACK_DEPTH-1:0] match, pre, snd;
   logic          found;
   logic          keep, need;
   logic [6:0]    cur_note;
   logic          playing, free_found;
   logic [VW-1:0] free_idx;
   logic          out_free;

   // effective polyphony clamped to 1..VOICES
   always_comb begin
      if (polyphony == 4'd0) begin
         poly8 = 8'd1;
      end else if ({4'd0, polyphony} > 8'(VOICES)) begin
         poly8 = 8'(VOICES);
      end else begin
         poly8 = {4'd0, polyphony};
      end
      tot8   = 8'(total_ff);
      first8 = (tot8 > poly8) ? (tot8 - poly8) : 8'd0;
      first  = CW'(first8);
   end

   // parallel compares over the stack
   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         match[i] = (CW'(i) < total_ff) && (held_ff[i] == ev.pitch);
         snd[i]   = (CW'(i) >= first) && (CW'(i) < total_ff);
      end
      pre[0] = match[0];
      for (int i = 1; i < STACK_DEPTH; i++) begin
         pre[i] = pre[i-1] | match[i];
      end
      found = |match;
   end

   always_comb begin
      keep = 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         if (snd[i] && (held_ff[i] == voice_ff[vidx_ff])) begin
            keep = 1'b1;
         end
      end
      if (8'(vidx_ff) >= poly8) begin
         keep = 1'b0;
      end
   end

   always_comb begin
      cur_note   = held_ff[sidx_ff[SW-1:0]];
      playing    = 1'b0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int j = VOICES - 1; j >= 0; j--) begin
         if (8'(j) < poly8) begin
            if (voice_ff[j] == cur_note) begin
               playing = 1'b1;
            end
            if (voice_ff[j] == 7'd0) begin
               free_found = 1'b1;
               free_idx   = VW'(j);
            end
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;
      total_in = total_ff;
      voice_in = voice_ff;
      gate_in  = gate_ff;
      vidx_in  = vidx_ff;
      sidx_in  = sidx_ff;
      ign_in   = ign_ff;
      ev_ready = 1'b0;
      need     = 1'b0;
      emit     = 1'b0;
      e_kind   = KIND_VOICE;
      e_voice  = 3'd0;
      e_pitch  = 7'd0;
      e_retrig = 1'b0;
      e_gate   = gate_ff;
      e_ign    = 1'b0;
      e_last   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (ev_valid) begin
               ev_ready = 1'b1;
               if (ev.ignored) begin
                  ign_in   = 1'b1;
                  state_in = ST_STATUS;
               end else begin
                  ign_in   = 1'b0;
                  vidx_in  = '0;
                  state_in = ST_FREE;
                  if (ev.action == ACTION_ON) begin
                     if (!found) begin
                        if (total_ff < CW'(STACK_DEPTH)) begin
                           held_in[total_ff[SW-1:0]] = ev.pitch;
                           total_in = total_ff + CW'(1);
                        end else begin
                           // full: drop the oldest entry
                           for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                              held_in[i] = held_ff[i+1];
                           end
                           held_in[STACK_DEPTH-1] = ev.pitch;
                        end
                     end
                  end else begin
                     // close the gap above the removed pitch
                     for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                        if (pre[i] && (CW'(i + 1) < total_ff)) begin
                           held_in[i] = held_ff[i+1];
                        end
                     end
                     if (found) begin
                        total_in = total_ff - CW'(1);
                     end
                  end
               end
            end
         end
         ST_FREE: begin
            need = (voice_ff[vidx_ff] != 7'd0) && !keep;
            if (!need || out_free) begin
               if (need) begin
                  voice_in[vidx_ff] = 7'd0;
                  emit    = 1'b1;
                  e_voice = 3'(vidx_ff);
               end
               if (vidx_ff == VW'(VOICES - 1)) begin
                  sidx_in  = first;
                  state_in = ST_ASSIGN;
                  if (total_ff == '0) begin
                     gate_in = 1'b0;
                  end
               end else begin
                  vidx_in = vidx_ff + VW'(1);
               end
            end
         end
         ST_ASSIGN: begin
            if (sidx_ff >= total_ff) begin
               state_in = ST_STATUS;
            end else begin
               need = (cur_note != 7'd0) && !playing && free_found;
               if (!need || out_free) begin
                  if (need) begin
                     voice_in[free_idx] = cur_note;
                     gate_in  = 1'b1;
                     emit     = 1'b1;
                     e_voice  = 3'(free_idx);
                     e_pitch  = cur_note;
                     e_retrig = 1'b1;
                     e_gate   = 1'b1;
                  end
                  sidx_in = sidx_ff + CW'(1);
               end
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               emit     = 1'b1;
               e_kind   = KIND_STATUS;
               e_ign    = ign_ff;
               e_last   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         gate_ff      <= 1'b0;
         vidx_ff      <= '0;
         sidx_ff      <= '0;
         ign_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < VOICES; j++) begin
            voice_ff[j] <= 7'd0;
         end
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         gate_ff  <= gate_in;
         vidx_ff  <= vidx_in;
         sidx_ff  <= sidx_in;
         ign_ff   <= ign_in;
         voice_ff <= voice_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (emit) begin
         rsp_kind_ff        <= e_kind;
         rsp_voice_ff       <= e_voice;
         rsp_voice_pitch_ff <= e_pitch;
         rsp_retrigger_ff   <= e_retrig;
         rsp_held_count_ff  <= 4'(total_ff);
         rsp_gate_ff        <= e_gate;
         rsp_ignored_ff     <= e_ign;
         rsp_last_ff        <= e_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_voice       = rsp_voice_ff;
   assign rsp_voice_pitch = rsp_voice_pitch_ff;
   assign rsp_retrigger   = rsp_retrigger_ff;
   assign rsp_held_count  = rsp_held_count_ff;
   assign rsp_gate        = rsp_gate_ff;
   assign rsp_ignored     = rsp_ignored_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ hdl/midi_note_stack_voice_allocator_top.sv @@
// midi_note_stack_voice_allocator_top: configuration registers, front and back
// depends on nsva_pkg, nsva_front, nsva_back
//
// usage:
//  req_ channel carries one note event (action 0 on / 1 off, pitch); a
//  transaction is taken when req_valid and req_ready are both high
//  rsp_ channel gives one result per voice change and then a status result
//  with rsp_last high; the stream of one event is contiguous
//  csr_ channel writes polyphony (0), lowest_note (1) and note_span (2);
//  csr_ready is always high, writes belong in idle periods
//  a two-entry queue sits between the front and the sequencer, so up to two
//  events are taken while the sequencer is busy
//  an accepted event runs the voice free pass over all VOICES, then the
//  assign pass over the sounding notes, then the status result; an ignored
//  pitch goes straight to the status result; the sequencer handles one
//  event at a time, and the voice free pass walks one voice per cycle
//  unless freeing a voice must wait for a held result register
//  a stalled receiver holds the result register and the sequencer waits on
//  it; the queue then fills and req_ready drops
//  reset clears the held count, frees all voices, drops the gate and loads
//  polyphony 1, lowest note 48, span 53
module midi_note_stack_voice_allocator_top
   import nsva_pkg::*;
#(
   parameter int STACK_DEPTH = 10,
   parameter int VOICES      = 8
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [6:0] req_pitch,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [2:0] rsp_voice,
   output logic [6:0] rsp_voice_pitch,
   output logic       rsp_retrigger,
   output logic [3:0] rsp_held_count,
   output logic       rsp_gate,
   output logic       rsp_ignored,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data
);

   logic [3:0] polyphony_ff;
   logic [6:0] lowest_note_ff;
   logic [6:0] note_span_ff;
   logic       ev_valid, ev_ready;
   event_type  ev;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         polyphony_ff   <= POLYPHONY_RESET;
         lowest_note_ff <= LOWEST_NOTE_RESET;
         note_span_ff   <= NOTE_SPAN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POLYPHONY:   polyphony_ff   <= csr_data[3:0];
            CSR_LOWEST_NOTE: lowest_note_ff <= csr_data;
            CSR_NOTE_SPAN:   note_span_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   nsva_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_pitch   (req_pitch),
      .lowest_note (lowest_note_ff),
      .note_span   (note_span_ff),
      .ev_valid    (ev_valid),
      .ev_ready    (ev_ready),
      .ev          (ev)
   );

   nsva_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .VOICES      (VOICES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .polyphony       (polyphony_ff),
      .ev_valid        (ev_valid),
      .ev_ready        (ev_ready),
      .ev              (ev),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_voice       (rsp_voice),
      .rsp_voice_pitch (rsp_voice_pitch),
      .rsp_retrigger   (rsp_retrigger),
      .rsp_held_count  (rsp_held_count),
      .rsp_gate        (rsp_gate),
      .rsp_ignored     (rsp_ignored),
      .rsp_last        (rsp_last)
   );

   // only the status result closes an event
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == KIND_STATUS)
      else $error("last flag on a voice change result");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATUS |->
         rsp_voice == 3'd0 && rsp_voice_pitch == 7'd0 && !rsp_retrigger)
      else $error("status result carries voice data");

   a_retrig_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_retrigger |-> rsp_gate && rsp_voice_pitch != 7'd0)
      else $error("retrigger without gate or note");

   a_ignored_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignored |-> rsp_last)
      else $error("ignored event gave a voice change");

endmodule
